// ===== sv/nsfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsfr_pkg: shared types and constants of the network settings responder
// frame markers, command codes, frame geometry and the reply sequencer states
// ----------------------------------------------------------------------------
package nsfr_pkg;

  localparam logic [7:0] START_MARK = 8'h53;
  localparam logic [7:0] END_MARK   = 8'h45;
  localparam logic [7:0] CMD_SET    = 8'h10;
  localparam logic [7:0] CMD_GET    = 8'h20;
  localparam logic [7:0] ACK_SET    = 8'h11;
  localparam logic [7:0] ACK_GET    = 8'h21;

  localparam int unsigned FRAME_LEN  = 18;
  localparam int unsigned STORE_LEN  = 14;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned ADDR_W     = 4;

  localparam logic [POS_W-1:0] POS_START = 5'd0;
  localparam logic [POS_W-1:0] POS_CMD   = 5'd1;
  localparam logic [POS_W-1:0] POS_DATA0 = 5'd2;
  localparam logic [POS_W-1:0] POS_DATAN = 5'd15;
  localparam logic [POS_W-1:0] POS_SUM   = 5'd16;
  localparam logic [POS_W-1:0] POS_END   = 5'd17;
  localparam logic [POS_W-1:0] POS_OVER  = 5'd18;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } nsfr_state_t;

endpackage : nsfr_pkg
`default_nettype wire

// ===== sv/nsfr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsfr_if: request channels of the network settings responder
// receive byte channel and reply byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface nsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, output rx_byte, output end_of_frame, input ready);
  modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface : nsfr_in_if

interface nsfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface : nsfr_out_if
`default_nettype wire

// ===== sv/network_settings_frame_responder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// network_settings_frame_responder: settings frame parser and reply generator
// Receive bytes arrive on in_ch, one request per byte, end_of_frame on the
// last one. A good 18-byte SET frame updates the stored settings and a good
// SET or GET frame is answered with an 18-byte reply on out_ch, last_byte set
// on the end marker. Bad frames are dropped without a reply.
// Receive bytes are taken only while no reply is being built.
// A reply is built by a fetch/send sequencer over two 14-byte memories
// (received payload and stored settings, registered read): each reply byte
// takes a fetch step, then a send step that loads it into the output
// register. in_ch is held off for the whole reply; the first reply byte
// goes out through the fetch step, the send step and the output register.
// A stall on out_ch holds the output register and the sequencer waits in its
// send step. Reset clears the frame parser, the sequencer and the valid bits
// of the settings memory, so the stored settings read as zero until the first
// good SET frame; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module network_settings_frame_responder (
  input  wire           clk,
  input  wire           rst_n,
  nsfr_in_if.sink       in_ch,
  nsfr_out_if.source    out_ch
);

  localparam int unsigned PW = nsfr_pkg::POS_W;
  localparam int unsigned AW = nsfr_pkg::ADDR_W;

  // receive parser
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    rx_sum_r, rx_sum_nxt;
  logic          bad_r, bad_nxt;
  logic          get_r, get_nxt;
  logic          in_acc;
  logic          frame_ok;

  // reply sequencer
  nsfr_pkg::nsfr_state_t st_r, st_nxt;
  logic [PW-1:0] tx_idx_r, tx_idx_nxt;
  logic [7:0]    tx_sum_r, tx_sum_nxt;
  logic          reply_get_r, reply_get_nxt;
  logic          rd_en;
  logic          out_load;
  logic          idx_data;
  logic [AW-1:0] tx_addr;
  logic [7:0]    tx_byte_c;

  // memories
  logic [7:0]    pay_mem [nsfr_pkg::STORE_LEN];
  logic [7:0]    set_mem [nsfr_pkg::STORE_LEN];
  logic [nsfr_pkg::STORE_LEN-1:0] set_vld_r;
  logic [7:0]    pay_rd_r;
  logic [7:0]    set_rd_r;
  logic          set_vld_rd_r;
  logic          pay_we;
  logic [AW-1:0] pay_addr;
  logic          set_we;

  // output register
  logic          out_vld_r, out_vld_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  assign in_ch.ready = (st_r == nsfr_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // ---------------- receive path ----------------
  always_comb begin
    bad_nxt    = bad_r;
    get_nxt    = get_r;
    rx_sum_nxt = rx_sum_r;
    pos_nxt    = pos_r;
    pay_we     = 1'b0;
    pay_addr   = AW'(pos_r - nsfr_pkg::POS_DATA0);
    case (pos_r) inside
      nsfr_pkg::POS_START: begin
        if (in_ch.rx_byte != nsfr_pkg::START_MARK) bad_nxt = 1'b1;
      end
      nsfr_pkg::POS_CMD: begin
        if (in_ch.rx_byte == nsfr_pkg::CMD_GET) begin
          get_nxt = 1'b1;
        end else if (in_ch.rx_byte != nsfr_pkg::CMD_SET) begin
          bad_nxt = 1'b1;
        end
      end
      [nsfr_pkg::POS_DATA0:nsfr_pkg::POS_DATAN]: begin
        pay_we = in_acc;
      end
      nsfr_pkg::POS_SUM: begin
        if (in_ch.rx_byte != rx_sum_r) bad_nxt = 1'b1;
      end
      nsfr_pkg::POS_END: begin
        if (in_ch.rx_byte != nsfr_pkg::END_MARK) bad_nxt = 1'b1;
      end
      default: begin
        bad_nxt = 1'b1;
      end
    endcase
    if (pos_r <= nsfr_pkg::POS_DATAN) rx_sum_nxt = rx_sum_r + in_ch.rx_byte;
    if (pos_r < nsfr_pkg::POS_OVER) pos_nxt = pos_r + 5'd1;
  end

  assign frame_ok = (pos_r == nsfr_pkg::POS_END) && !bad_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      rx_sum_r <= '0;
      bad_r    <= 1'b0;
      get_r    <= 1'b0;
    end else if (in_acc) begin
      if (in_ch.end_of_frame) begin
        // every closing byte starts a fresh frame
        pos_r    <= '0;
        rx_sum_r <= '0;
        bad_r    <= 1'b0;
        get_r    <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        rx_sum_r <= rx_sum_nxt;
        bad_r    <= bad_nxt;
        get_r    <= get_nxt;
      end
    end
  end

  // ---------------- reply sequencer ----------------
  assign idx_data = (tx_idx_r >= nsfr_pkg::POS_DATA0) && (tx_idx_r <= nsfr_pkg::POS_DATAN);
  assign tx_addr  = AW'(tx_idx_r - nsfr_pkg::POS_DATA0);
  assign out_load = (st_r == nsfr_pkg::ST_SEND) && (!out_vld_r || out_ch.ready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      nsfr_pkg::ST_IDLE: begin
        if (in_acc && in_ch.end_of_frame && frame_ok) st_nxt = nsfr_pkg::ST_FETCH;
      end
      nsfr_pkg::ST_FETCH: begin
        st_nxt = nsfr_pkg::ST_SEND;
      end
      nsfr_pkg::ST_SEND: begin
        if (out_load) begin
          st_nxt = (tx_idx_r == nsfr_pkg::POS_END) ? nsfr_pkg::ST_IDLE : nsfr_pkg::ST_FETCH;
        end
      end
      default: begin
        st_nxt = nsfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en         = 1'b0;
    set_we        = 1'b0;
    tx_idx_nxt    = tx_idx_r;
    tx_sum_nxt    = tx_sum_r;
    reply_get_nxt = reply_get_r;
    tx_byte_c     = nsfr_pkg::END_MARK;
    case (tx_idx_r) inside
      nsfr_pkg::POS_START: tx_byte_c = nsfr_pkg::START_MARK;
      nsfr_pkg::POS_CMD:   tx_byte_c = reply_get_r ? nsfr_pkg::ACK_GET : nsfr_pkg::ACK_SET;
      [nsfr_pkg::POS_DATA0:nsfr_pkg::POS_DATAN]: begin
        // unwritten settings entries read as zero
        tx_byte_c = reply_get_r ? (set_vld_rd_r ? set_rd_r : 8'h00) : pay_rd_r;
      end
      nsfr_pkg::POS_SUM:   tx_byte_c = tx_sum_r;
      default:             tx_byte_c = nsfr_pkg::END_MARK;
    endcase
    case (st_r)
      nsfr_pkg::ST_IDLE: begin
        if (in_acc && in_ch.end_of_frame && frame_ok) begin
          tx_idx_nxt    = '0;
          tx_sum_nxt    = '0;
          reply_get_nxt = get_nxt;
        end
      end
      nsfr_pkg::ST_FETCH: begin
        rd_en = idx_data;
      end
      nsfr_pkg::ST_SEND: begin
        if (out_load) begin
          tx_idx_nxt = tx_idx_r + 5'd1;
          tx_sum_nxt = tx_sum_r + tx_byte_c;
          set_we     = idx_data && !reply_get_r;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= nsfr_pkg::ST_IDLE;
      tx_idx_r    <= '0;
      tx_sum_r    <= '0;
      reply_get_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tx_idx_r    <= tx_idx_nxt;
      tx_sum_r    <= tx_sum_nxt;
      reply_get_r <= reply_get_nxt;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_addr] <= in_ch.rx_byte;
    if (rd_en) pay_rd_r <= pay_mem[tx_addr];
  end

  // settings take the payload byte as it goes out on a set reply
  always_ff @(posedge clk) begin
    if (set_we) set_mem[tx_addr] <= pay_rd_r;
    if (rd_en) set_rd_r <= set_mem[tx_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_vld_r    <= '0;
      set_vld_rd_r <= 1'b0;
    end else begin
      if (set_we) set_vld_r[tx_addr] <= 1'b1;
      if (rd_en) set_vld_rd_r <= set_vld_r[tx_addr];
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= tx_byte_c;
      out_last_r <= (tx_idx_r == nsfr_pkg::POS_END);
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.tx_byte   = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  // ---------------- assertions ----------------
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= nsfr_pkg::POS_OVER)
    else $error("frame position beyond limit");

  a_no_rx_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != nsfr_pkg::ST_IDLE) |-> !in_acc)
    else $error("receive request taken during reply");

  a_last_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && tx_idx_r == nsfr_pkg::POS_END) |=>
      (out_vld_r && out_last_r && st_r == nsfr_pkg::ST_IDLE))
    else $error("end marker did not close the reply");

  a_set_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
    set_we |-> (!reply_get_r && st_r == nsfr_pkg::ST_SEND))
    else $error("settings written outside a set reply");

endmodule : network_settings_frame_responder
`default_nettype wire

// ===== tb/nsfr_tb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsfr_tb_pkg: settings frame scoreboard for the responder testbench
// tracks the receive parser and the stored settings, queues reply bytes on
// every good frame and checks the reply stream against them in order
// ----------------------------------------------------------------------------
package nsfr_tb_pkg;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } reply_beat_t;

  class settings_scoreboard;
    logic [31:0]      ip_reg;
    logic [31:0]      mask_reg;
    logic [31:0]      gateway_reg;
    logic [15:0]      port_reg;
    logic [7:0]       rx_payload [nsfr_pkg::STORE_LEN];
    logic [nsfr_pkg::POS_W-1:0] rx_pos;
    logic [7:0]       rx_sum;
    logic             rx_bad;
    logic             rx_get;
    reply_beat_t      reply_q [$];
    int               mismatches;

    function new();
      ip_reg      = '0;
      mask_reg    = '0;
      gateway_reg = '0;
      port_reg    = '0;
      rx_pos      = nsfr_pkg::POS_START;
      rx_sum      = '0;
      rx_bad      = 1'b0;
      rx_get      = 1'b0;
      mismatches  = 0;
    endfunction

    function void clear_frame();
      rx_pos = nsfr_pkg::POS_START;
      rx_sum = '0;
      rx_bad = 1'b0;
      rx_get = 1'b0;
    endfunction

    function void note_request(input logic [7:0] b, input logic eof);
      logic [nsfr_pkg::POS_W-1:0] p;
      logic [7:0]       reply [nsfr_pkg::FRAME_LEN];
      logic [7:0]       sum;
      reply_beat_t      beat;
      p = rx_pos;
      if (p >= nsfr_pkg::POS_OVER) begin
        rx_bad = 1'b1;
      end else if (p == nsfr_pkg::POS_START) begin
        if (b != nsfr_pkg::START_MARK) rx_bad = 1'b1;
      end else if (p == nsfr_pkg::POS_CMD) begin
        if (b == nsfr_pkg::CMD_GET) rx_get = 1'b1;
        else if (b != nsfr_pkg::CMD_SET) rx_bad = 1'b1;
      end else if (p <= nsfr_pkg::POS_DATAN) begin
        rx_payload[p - nsfr_pkg::POS_DATA0] = b;
      end else if (p == nsfr_pkg::POS_SUM) begin
        if (b != rx_sum) rx_bad = 1'b1;
      end else begin
        if (b != nsfr_pkg::END_MARK) rx_bad = 1'b1;
      end
      if (p <= nsfr_pkg::POS_DATAN) rx_sum = rx_sum + b;
      // position saturates once the frame is over length
      if (p < nsfr_pkg::POS_OVER) rx_pos = p + 1'b1;
      if (!eof) return;
      if (p != nsfr_pkg::POS_END || rx_bad) begin
        clear_frame();
        return;
      end
      if (!rx_get) begin
        ip_reg      = {rx_payload[0], rx_payload[1], rx_payload[2], rx_payload[3]};
        mask_reg    = {rx_payload[4], rx_payload[5], rx_payload[6], rx_payload[7]};
        gateway_reg = {rx_payload[8], rx_payload[9], rx_payload[10], rx_payload[11]};
        port_reg    = {rx_payload[12], rx_payload[13]};
      end
      reply[0] = nsfr_pkg::START_MARK;
      reply[1] = rx_get ? nsfr_pkg::ACK_GET : nsfr_pkg::ACK_SET;
      for (int i = 0; i < 4; i++) begin
        reply[2 + i]  = ip_reg[31 - 8*i -: 8];
        reply[6 + i]  = mask_reg[31 - 8*i -: 8];
        reply[10 + i] = gateway_reg[31 - 8*i -: 8];
      end
      reply[14] = port_reg[15:8];
      reply[15] = port_reg[7:0];
      sum = '0;
      for (int i = 0; i < 16; i++) sum = sum + reply[i];
      reply[16] = sum;
      reply[17] = nsfr_pkg::END_MARK;
      for (int i = 0; i < nsfr_pkg::FRAME_LEN; i++) begin
        beat.tx_byte   = reply[i];
        beat.last_byte = (i == nsfr_pkg::FRAME_LEN - 1);
        reply_q.push_back(beat);
      end
      clear_frame();
    endfunction

    function void check_reply(input logic [7:0] b, input logic last);
      reply_beat_t want;
      if (reply_q.size() == 0) begin
        $display("%0t: reply byte expected none actual %02h last_byte %0b", $time, b, last);
        mismatches++;
        return;
      end
      want = reply_q.pop_front();
      if (b !== want.tx_byte) begin
        $display("%0t: tx_byte expected %02h actual %02h", $time, want.tx_byte, b);
        mismatches++;
      end
      if (last !== want.last_byte) begin
        $display("%0t: last_byte expected %0b actual %0b", $time, want.last_byte, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return reply_q.size();
    endfunction
  endclass

endpackage : nsfr_tb_pkg
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the network settings frame responder
// drives good and broken settings frames plus noise with random gaps and
// reply stalls, including one long stall on the reply side, and checks every
// reply byte against the scoreboard
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum int {
    FAULT_NONE,
    FAULT_START,
    FAULT_CMD,
    FAULT_SUM,
    FAULT_END,
    FAULT_SHORT,
    FAULT_LONG
  } frame_fault_t;

  logic clk;
  logic rst_n;
  bit   calm;
  bit   hold_req;
  int unsigned requests_sent;
  nsfr_tb_pkg::settings_scoreboard sb;

  nsfr_in_if  in_ch ();
  nsfr_out_if out_ch ();

  network_settings_frame_responder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_request(in_ch.rx_byte, in_ch.end_of_frame);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_reply(out_ch.tx_byte, out_ch.last_byte);
    end
  end

  // reply side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(input logic [7:0] b, input logic eof);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.rx_byte      <= b;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    requests_sent++;
  endtask

  function automatic logic [111:0] random_settings();
    logic [15:0] port;
    int sel;
    port = 16'($urandom);
    sel  = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom, $urandom, port};
  endfunction

  task automatic send_frame(input logic [7:0] cmd, input logic [111:0] settings,
                            input frame_fault_t fault);
    logic [7:0] q [$];
    logic [7:0] sum;
    logic [7:0] x;
    int n;
    q.push_back(nsfr_pkg::START_MARK);
    q.push_back(cmd);
    for (int i = 0; i < nsfr_pkg::STORE_LEN; i++) q.push_back(settings[111 - 8*i -: 8]);
    if (fault == FAULT_START) begin
      do x = 8'($urandom_range(0, 255)); while (x == nsfr_pkg::START_MARK);
      q[0] = x;
    end
    if (fault == FAULT_CMD) begin
      do x = 8'($urandom_range(0, 255));
      while (x == nsfr_pkg::CMD_SET || x == nsfr_pkg::CMD_GET);
      q[1] = x;
    end
    sum = '0;
    foreach (q[i]) sum = sum + q[i];
    q.push_back(sum);
    q.push_back(nsfr_pkg::END_MARK);
    case (fault)
      FAULT_SUM: begin
        q[16] = q[16] ^ 8'($urandom_range(1, 255));
      end
      FAULT_END: begin
        q[17] = q[17] ^ 8'($urandom_range(1, 255));
      end
      FAULT_SHORT: begin
        n = $urandom_range(1, 17);
        while (q.size() > n) void'(q.pop_back());
      end
      FAULT_LONG: begin
        n = $urandom_range(1, 24);
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    foreach (q[i]) send_request(q[i], i == q.size() - 1);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_request(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
  endtask

  initial begin
    int frames;
    int r;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    requests_sent = 0;
    frames = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    in_ch.end_of_frame <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: settings read as zero after reset, extremes, each kind of bad frame
    send_frame(nsfr_pkg::CMD_GET, {$urandom, $urandom, $urandom, 16'($urandom)}, FAULT_NONE);
    send_frame(nsfr_pkg::CMD_SET, '0, FAULT_NONE);
    send_frame(nsfr_pkg::CMD_SET, '1, FAULT_NONE);
    send_frame(nsfr_pkg::CMD_GET, '0, FAULT_NONE);
    send_frame(nsfr_pkg::CMD_SET, {$urandom, $urandom, $urandom, 16'($urandom)}, FAULT_NONE);
    send_frame(nsfr_pkg::CMD_SET, '1, FAULT_START);
    send_frame(nsfr_pkg::CMD_SET, '0, FAULT_CMD);
    send_frame(nsfr_pkg::CMD_SET, '1, FAULT_SUM);
    send_frame(nsfr_pkg::CMD_SET, '0, FAULT_END);
    send_frame(nsfr_pkg::CMD_SET, '1, FAULT_SHORT);
    send_frame(nsfr_pkg::CMD_SET, '0, FAULT_LONG);
    send_request(nsfr_pkg::START_MARK, 1'b1);
    // well past the length limit, the position counter must saturate
    repeat (40) send_request(8'($urandom_range(0, 255)), 1'b0);
    send_request(nsfr_pkg::END_MARK, 1'b1);
    send_frame(nsfr_pkg::CMD_GET, '1, FAULT_NONE);

    while (requests_sent < 350) begin
      if (requests_sent > 300) calm = 1'b1;
      r = $urandom_range(0, 9);
      if (r < 6) begin
        send_frame($urandom_range(0, 1) ? nsfr_pkg::CMD_GET : nsfr_pkg::CMD_SET,
                   random_settings(), FAULT_NONE);
      end else if (r < 9) begin
        send_frame($urandom_range(0, 1) ? nsfr_pkg::CMD_GET : nsfr_pkg::CMD_SET,
                   random_settings(),
                   frame_fault_t'($urandom_range(FAULT_START, FAULT_LONG)));
      end else begin
        send_noise($urandom_range(1, 20));
      end
      frames++;
      // reply side holds off while the next frame is offered
      if (frames == 4) hold_req = 1'b1;
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule : tb_top
`default_nettype wire

// ===== files.f =====
sv/nsfr_pkg.sv
sv/nsfr_if.sv
sv/network_settings_frame_responder.sv
tb/nsfr_tb_pkg.sv
tb/tb_top.sv
